// ===== hw/rtl/pct_pkg.sv =====
// ============================================================================
// pct_pkg: shared types and helpers for the pausable countdown timer
// Command codes, beat payload structs and saturating count arithmetic.
// ============================================================================
package pct_pkg;

    // Width of the internal signed tick count.
    localparam int COUNT_WIDTH = 32;

    // Width wide enough to hold both a 32-bit port value and a count value,
    // plus one bit so that clamping compares never overflow.
    localparam int WIDE_WIDTH = (COUNT_WIDTH > 32 ? COUNT_WIDTH : 32) + 1;

    typedef logic signed [COUNT_WIDTH-1:0] t_cnt;
    typedef logic signed [WIDE_WIDTH-1:0]  t_wide;

    localparam t_cnt CNT_MAX  = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam t_cnt CNT_MIN  = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam t_cnt CNT_ZERO = '0;
    localparam t_cnt CNT_ONE  = t_cnt'(1);

    // Command codes.
    localparam logic [3:0] OP_TICK    = 4'd0;
    localparam logic [3:0] OP_ENABLE  = 4'd1;
    localparam logic [3:0] OP_DISABLE = 4'd2;
    localparam logic [3:0] OP_START   = 4'd3;
    localparam logic [3:0] OP_STOP    = 4'd4;
    localparam logic [3:0] OP_CHANGE  = 4'd5;
    localparam logic [3:0] OP_SET     = 4'd6;
    localparam logic [3:0] OP_ADD     = 4'd7;
    localparam logic [3:0] OP_PAUSE   = 4'd8;
    localparam logic [3:0] OP_RESUME  = 4'd9;
    localparam logic [3:0] OP_QUERY   = 4'd10;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] amount;
    } t_cmd;

    typedef struct packed {
        logic [30:0]        time_left;
        logic signed [31:0] round_length;
        logic               is_enabled;
        logic               is_running;
        logic               is_frozen;
        logic               run_out;
    } t_result;

    // Saturating signed add on the count width.
    function automatic t_cnt sat_add(t_cnt a, t_cnt b);
        logic signed [COUNT_WIDTH:0] s;
        s = {a[COUNT_WIDTH-1], a} + {b[COUNT_WIDTH-1], b};
        if (s[COUNT_WIDTH] != s[COUNT_WIDTH-1]) begin
            return s[COUNT_WIDTH] ? CNT_MIN : CNT_MAX;
        end
        return s[COUNT_WIDTH-1:0];
    endfunction

    // Saturating signed subtract on the count width.
    function automatic t_cnt sat_sub(t_cnt a, t_cnt b);
        logic signed [COUNT_WIDTH:0] s;
        s = {a[COUNT_WIDTH-1], a} - {b[COUNT_WIDTH-1], b};
        if (s[COUNT_WIDTH] != s[COUNT_WIDTH-1]) begin
            return s[COUNT_WIDTH] ? CNT_MIN : CNT_MAX;
        end
        return s[COUNT_WIDTH-1:0];
    endfunction

    // Clamp a 32-bit command amount into the count range.
    function automatic t_cnt clamp_amount(logic signed [31:0] amt);
        t_wide w;
        t_wide hi;
        t_wide lo;
        w  = t_wide'(amt);
        hi = t_wide'(CNT_MAX);
        lo = t_wide'(CNT_MIN);
        if (w > hi) begin
            return CNT_MAX;
        end
        if (w < lo) begin
            return CNT_MIN;
        end
        return w[COUNT_WIDTH-1:0];
    endfunction

    // Remaining time as reported: zero unless positive, capped at 2^31-1.
    function automatic logic [30:0] report_left(t_cnt ticks);
        t_wide w;
        t_wide cap;
        w   = t_wide'(ticks);
        cap = t_wide'(32'sh7FFF_FFFF);
        if (w <= t_wide'(0)) begin
            return '0;
        end
        if (w > cap) begin
            return '1;
        end
        return w[30:0];
    endfunction

    // Nominal length saturated to the 32-bit signed port range.
    function automatic logic signed [31:0] report_length(t_cnt len);
        t_wide w;
        w = t_wide'(len);
        if (w > t_wide'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end
        if (w < t_wide'(-33'sh1_0000_0000 / 2)) begin
            return 32'sh8000_0000;
        end
        return w[31:0];
    endfunction

endpackage

// ===== hw/rtl/pausable_countdown_timer.sv =====
// ============================================================================
// pausable_countdown_timer: command-driven countdown timer with pause
// Applies one command beat per cycle while the result side takes beats, and returns the timer state after it.
// ============================================================================
// Each accepted command beat (tick, enable, disable, start, stop, change
// length, set current, add time, pause, resume, query) produces exactly one
// result beat that shows the timer state after the command took effect. The
// block takes one command per clock cycle: the whole update is one saturating
// add-and-compare path from the state registers to the result register, so
// a result appears in the cycle after its command is accepted and a new command
// is taken in every cycle while the result side keeps taking beats. The input
// is ready whenever the result register is empty or is being drained in the
// same cycle.
module pausable_countdown_timer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pct_pkg::t_cmd    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pct_pkg::t_result o_out_data
);

    // Timer state.
    logic          r_enabled, n_enabled;
    logic          r_running, n_running;
    logic          r_frozen,  n_frozen;
    pct_pkg::t_cnt r_ticks,   n_ticks;
    pct_pkg::t_cnt r_length,  n_length;

    // Result register.
    logic             r_out_valid, n_out_valid;
    pct_pkg::t_result r_out_data,  n_out_data;

    logic          in_beat;
    pct_pkg::t_cnt amt;
    pct_pkg::t_cnt diff;
    pct_pkg::t_cnt chg_ticks;
    pct_pkg::t_cnt add_ticks;

    // The result register can take a new beat when it is empty or when its
    // current beat leaves in this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    assign amt       = pct_pkg::clamp_amount(i_in_data.amount);
    // Change length shifts the live count by the difference between the new
    // and the old nominal length.
    assign diff      = pct_pkg::sat_sub(amt, r_length);
    assign chg_ticks = pct_pkg::sat_add(r_ticks, diff);
    assign add_ticks = pct_pkg::sat_add(r_ticks, amt);

    always_comb begin
        n_enabled = r_enabled;
        n_running = r_running;
        n_frozen  = r_frozen;
        n_ticks   = r_ticks;
        n_length  = r_length;

        if (in_beat) begin
            unique case (i_in_data.op) inside
                pct_pkg::OP_TICK: begin
                    if (r_running && !r_frozen) begin
                        n_ticks = pct_pkg::sat_sub(r_ticks, pct_pkg::CNT_ONE);
                    end
                end
                pct_pkg::OP_ENABLE: begin
                    n_enabled = 1'b1;
                end
                pct_pkg::OP_DISABLE: begin
                    n_enabled = 1'b0;
                    n_running = 1'b0;
                    n_frozen  = 1'b0;
                    n_ticks   = pct_pkg::CNT_ZERO;
                    n_length  = pct_pkg::CNT_ZERO;
                end
                pct_pkg::OP_STOP: begin
                    n_running = 1'b0;
                    n_frozen  = 1'b0;
                    n_ticks   = pct_pkg::CNT_ZERO;
                    n_length  = pct_pkg::CNT_ZERO;
                end
                pct_pkg::OP_START, pct_pkg::OP_CHANGE, pct_pkg::OP_SET: begin
                    if (r_enabled) begin
                        if (amt <= pct_pkg::CNT_ZERO) begin
                            // A non-positive length stops the timer.
                            n_running = 1'b0;
                            n_frozen  = 1'b0;
                            n_ticks   = pct_pkg::CNT_ZERO;
                            n_length  = pct_pkg::CNT_ZERO;
                        end else if (i_in_data.op == pct_pkg::OP_START || !r_running) begin
                            // Start, or a length command on a stopped timer.
                            n_running = 1'b1;
                            n_frozen  = 1'b0;
                            n_ticks   = amt;
                            n_length  = amt;
                        end else if (i_in_data.op == pct_pkg::OP_CHANGE &&
                                     chg_ticks > pct_pkg::CNT_ZERO) begin
                            n_ticks  = chg_ticks;
                            n_length = pct_pkg::sat_add(r_length, diff);
                        end else begin
                            // Set current, or a change that would leave no
                            // time: the amount becomes both count and length.
                            // The count stays positive, so a paused timer
                            // simply stays paused.
                            n_ticks  = amt;
                            n_length = amt;
                        end
                    end
                end
                pct_pkg::OP_ADD: begin
                    // The new count is never negative, so the pause state
                    // carries over unchanged.
                    if (r_enabled && r_running) begin
                        if (add_ticks > pct_pkg::CNT_ZERO) begin
                            n_ticks  = add_ticks;
                            n_length = pct_pkg::sat_add(r_length, amt);
                        end else begin
                            n_ticks  = pct_pkg::CNT_ZERO;
                            n_length = pct_pkg::CNT_ONE;
                        end
                    end
                end
                pct_pkg::OP_PAUSE: begin
                    if (r_running && !r_frozen) begin
                        n_frozen = 1'b1;
                        if (r_ticks < pct_pkg::CNT_ZERO) begin
                            n_ticks = pct_pkg::CNT_ZERO;
                        end
                    end
                end
                pct_pkg::OP_RESUME: begin
                    if (r_running && r_frozen) begin
                        n_frozen = 1'b0;
                        if (r_ticks < pct_pkg::CNT_ZERO) begin
                            n_ticks = pct_pkg::CNT_ZERO;
                        end
                    end
                end
                default: begin
                    // Query and the unused codes leave the state alone.
                end
            endcase
        end
    end

    // Result beat built from the updated state.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (in_beat) begin
            n_out_valid             = 1'b1;
            n_out_data.time_left    = n_running ? pct_pkg::report_left(n_ticks) : '0;
            n_out_data.round_length = pct_pkg::report_length(n_length);
            n_out_data.is_enabled   = n_enabled;
            n_out_data.is_running   = n_running;
            n_out_data.is_frozen    = n_frozen;
            n_out_data.run_out      = n_running && (n_ticks <= pct_pkg::CNT_ZERO);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_running   <= 1'b0;
            r_frozen    <= 1'b0;
            r_ticks     <= pct_pkg::CNT_ZERO;
            r_length    <= pct_pkg::CNT_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_enabled   <= n_enabled;
            r_running   <= n_running;
            r_frozen    <= n_frozen;
            r_ticks     <= n_ticks;
            r_length    <= n_length;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/pct_checker.sv =====
// ============================================================================
// pct_checker: port-level checks for the pausable countdown timer
// Watches the top-level ports and flags inconsistent result beats.
// ============================================================================
module pct_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input pct_pkg::t_cmd    i_in_data,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input pct_pkg::t_result o_out_data
);

    // Every accepted command beat shows up as a result beat in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("command beat produced no result beat");

    // A stalled result beat holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

    // A stopped timer is never paused and has no length or time left.
    a_stopped_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_running) |->
        (!o_out_data.is_frozen && o_out_data.round_length == 32'sd0 &&
         o_out_data.time_left == 31'd0 && !o_out_data.run_out))
        else $error("stopped timer reports live state");

    // A run-out timer reports no time left.
    a_run_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.run_out) |-> (o_out_data.time_left == 31'd0))
        else $error("run-out timer reports time left");

endmodule

bind pausable_countdown_timer pct_checker u_pct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
